FILE: rtl/aimd_pkg.sv
// Shared types and constants for the AIMD rate-factor controller.
// Depends on nothing; every other file of the block imports it.
package aimd_pkg;

  // Field widths
  localparam int unsigned FACTOR_W   = 16;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned BASE_W     = 15;
  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // Shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 16;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Frequency is the triple product shifted down by 24, then clamped
  localparam int unsigned FREQ_SHIFT = 24;
  localparam int unsigned FREQ_RAW_W = MUL_P_W - FREQ_SHIFT;

  // Constants (Q4.12 one, Q8.8 clamp 0.1 Hz .. 200 Hz)
  localparam logic [FACTOR_W-1:0]   FACTOR_ONE = 16'd4096;
  localparam logic [FREQ_RAW_W-1:0] FREQ_MIN   = FREQ_RAW_W'(26);
  localparam logic [FREQ_RAW_W-1:0] FREQ_MAX   = FREQ_RAW_W'(51200);

  typedef enum logic [1:0] {
    ALG_NONE  = 2'd0,
    ALG_AIMD  = 2'd1,
    ALG_BIC   = 2'd2,
    ALG_CUBIC = 2'd3
  } alg_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALGORITHM  = 3'd0,
    REG_INC_STEP   = 3'd1,
    REG_DEC_MULT   = 3'd2,
    REG_MIN_FACTOR = 3'd3,
    REG_MAX_FACTOR = 3'd4,
    REG_INC_INTVL  = 3'd5,
    REG_BASE_FREQ  = 3'd6,
    REG_BURST      = 3'd7
  } reg_e;

  typedef struct packed {
    alg_e                algorithm;
    logic [FACTOR_W-1:0] increase_step;
    logic [FACTOR_W-1:0] decrease_mult;
    logic [FACTOR_W-1:0] min_factor;
    logic [FACTOR_W-1:0] max_factor;
    logic [COUNT_W-1:0]  increase_interval;
    logic [BASE_W-1:0]   base_freq;
    logic [FACTOR_W-1:0] burst_factor;
  } cfg_t;

endpackage

FILE: rtl/aimd_mul.sv
// Shared 32x16 multiplier with a registered product and a load enable.
// Depends on aimd_pkg for operand widths.
module aimd_mul (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [aimd_pkg::MUL_A_W-1:0] a_i,
  input  logic [aimd_pkg::MUL_B_W-1:0] b_i,
  output logic [aimd_pkg::MUL_P_W-1:0] p_o
);
  import aimd_pkg::*;

  logic [MUL_P_W-1:0] p_q;

  // Product holds while not enabled so a stalled sequencer keeps it
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

FILE: rtl/aimd_ctrl.sv
// Event sequencer: rate-factor state, decrease/increase, frequency, output beat.
// Depends on aimd_pkg and drives one aimd_mul instance.
module aimd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aimd_pkg::cfg_t                cfg_i,
  input  logic                          alg_clr_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic                          congestion_mark_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [aimd_pkg::FACTOR_W-1:0] rate_factor_o,
  output logic [aimd_pkg::FREQ_W-1:0]   frequency_o,
  output logic                          decreased_o,
  output logic                          increased_o,
  output logic [aimd_pkg::FACTOR_W-1:0] peak_factor_o
);
  import aimd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_DECW,
    S_F1,
    S_F2,
    S_F3
  } state_e;

  state_e              state_q;
  logic [FACTOR_W-1:0] factor_q;
  logic [COUNT_W-1:0]  count_q;
  logic [FACTOR_W-1:0] peak_q;
  logic                dec_q;
  logic                inc_q;
  logic                cubic_mark_q;
  logic                out_valid_q;
  logic [FACTOR_W-1:0] out_factor_q;
  logic [FREQ_W-1:0]   out_freq_q;
  logic                out_dec_q;
  logic                out_inc_q;
  logic [FACTOR_W-1:0] out_peak_q;

  logic               accept;
  logic               is_dec;
  logic [COUNT_W-1:0] count_inc;
  logic               do_inc;
  logic [FACTOR_W:0]  inc_sum;
  logic [FACTOR_W-1:0] inc_factor;
  logic [FACTOR_W-1:0] dec_prod;
  logic [FACTOR_W-1:0] dec_factor;
  logic [FREQ_RAW_W-1:0] freq_raw;
  logic [FREQ_W-1:0]   freq_clamped;
  logic                out_free;

  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Event decode and the additive-increase path (one add, one compare each)
  always_comb begin
    is_dec    = (cfg_i.algorithm != ALG_NONE) && (op_i || congestion_mark_i);
    count_inc = count_q + COUNT_W'(1);
    do_inc    = (cfg_i.algorithm != ALG_NONE) && !op_i && !congestion_mark_i &&
                (count_inc >= cfg_i.increase_interval);
    inc_sum   = {1'b0, factor_q} + {1'b0, cfg_i.increase_step};
    if (inc_sum > {1'b0, cfg_i.max_factor}) begin
      inc_factor = cfg_i.max_factor;
    end else begin
      inc_factor = inc_sum[FACTOR_W-1:0];
    end
  end

  // Decrease result: Q4.12 * Q0.16 >> 16, floored
  always_comb begin
    dec_prod = mul_p[2*FACTOR_W-1:FACTOR_W];
    if (dec_prod < cfg_i.min_factor) begin
      dec_factor = cfg_i.min_factor;
    end else begin
      dec_factor = dec_prod;
    end
  end

  // Frequency clamp on the triple product
  always_comb begin
    freq_raw = mul_p[MUL_P_W-1:FREQ_SHIFT];
    if (freq_raw < FREQ_MIN) begin
      freq_clamped = FREQ_W'(FREQ_MIN);
    end else if (freq_raw > FREQ_MAX) begin
      freq_clamped = FREQ_W'(FREQ_MAX);
    end else begin
      freq_clamped = freq_raw[FREQ_W-1:0];
    end
  end

  // Multiplier operand select per step
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_DEC: begin
        mul_a = MUL_A_W'(factor_q);
        mul_b = cfg_i.decrease_mult;
      end
      S_F1: begin
        mul_a = MUL_A_W'(cfg_i.base_freq);
        mul_b = factor_q;
      end
      S_F2: begin
        mul_a = mul_p[MUL_A_W-1:0];
        mul_b = cfg_i.burst_factor;
      end
      S_IDLE, S_DECW, S_F3: begin
        mul_en = 1'b0;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  aimd_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Sequencer, controller state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      factor_q     <= FACTOR_ONE;
      count_q      <= '0;
      peak_q       <= '0;
      dec_q        <= 1'b0;
      inc_q        <= 1'b0;
      cubic_mark_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_factor_q <= '0;
      out_freq_q   <= '0;
      out_dec_q    <= 1'b0;
      out_inc_q    <= 1'b0;
      out_peak_q   <= '0;
    end else begin
      // Beat taken by the receiver; in S_F3 the slot is handled below
      if (out_valid_q && !out_stall_i && (state_q != S_F3)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            dec_q        <= is_dec;
            inc_q        <= do_inc;
            cubic_mark_q <= (cfg_i.algorithm == ALG_CUBIC) && !op_i && congestion_mark_i;
            if (is_dec) begin
              state_q <= S_DEC;
            end else begin
              if (cfg_i.algorithm != ALG_NONE) begin
                if (do_inc) begin
                  factor_q <= inc_factor;
                  count_q  <= '0;
                end else begin
                  count_q  <= count_inc;
                end
              end
              state_q <= S_F1;
            end
          end
        end
        S_DEC: state_q <= S_DECW;
        S_DECW: begin
          factor_q <= dec_factor;
          count_q  <= '0;
          if (cubic_mark_q) begin
            peak_q <= dec_factor;
          end
          state_q <= S_F1;
        end
        S_F1: state_q <= S_F2;
        S_F2: state_q <= S_F3;
        S_F3: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_factor_q <= factor_q;
            out_freq_q   <= freq_clamped;
            out_dec_q    <= dec_q;
            out_inc_q    <= inc_q;
            out_peak_q   <= peak_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // Algorithm write restarts the controller state
      if (alg_clr_i) begin
        factor_q <= FACTOR_ONE;
        count_q  <= '0;
        peak_q   <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign rate_factor_o = out_factor_q;
  assign frequency_o   = out_freq_q;
  assign decreased_o   = out_dec_q;
  assign increased_o   = out_inc_q;
  assign peak_factor_o = out_peak_q;

`ifndef ASSERT_OFF
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_dec_q && out_inc_q))
    else $error("decrease and increase flagged on one beat");

  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECW && !alg_clr_i) |=> (factor_q >= $past(cfg_i.min_factor)))
    else $error("decreased factor below floor");

  a_freq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_freq_q >= FREQ_W'(FREQ_MIN) && out_freq_q <= FREQ_W'(FREQ_MAX)))
    else $error("frequency outside clamp");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("accepted event did not start the sequence");

  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_F3 && out_valid_q && out_stall_i) |=>
      (state_q == S_F3 && out_valid_q && $stable(out_freq_q)))
    else $error("result overwrote a stalled beat");
`endif

endmodule

FILE: rtl/aimd_rate_factor_controller_core.sv
// Top level of the AIMD rate-factor controller: configuration registers,
// channel ports and the event sequencer. Depends on aimd_pkg, aimd_ctrl, aimd_mul.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one event per beat:
//   op_i = 0 data arrival (congestion_mark_i flags a mark), op_i = 1 timeout.
//   Output channel (out_valid_o / out_stall_i) returns one result beat per
//   event: rate factor, frequency, decrease/increase flags and peak factor.
//   Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i);
//   a write to the algorithm register also restarts factor, count and peak.
// Sequencing:
//   One shared 32x16 multiplier is stepped by a sequencer. A decrease uses
//   it three times (factor, base, burst), other events twice. The result
//   beat is registered in S_F3, after S_DEC, S_DECW, S_F1, S_F2 (decrease) or
//   S_F1, S_F2; no new event is taken until the last one's beat is registered.
// Reset and stall:
//   rst_ni clears factor to 1.0, count and peak to zero and loads the
//   register defaults. While a result waits on out_stall_i, the block can
//   take the next event; it holds that event's result until the slot frees.
module aimd_rate_factor_controller_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aimd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aimd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic                            congestion_mark_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [aimd_pkg::FACTOR_W-1:0]   rate_factor_o,
  output logic [aimd_pkg::FREQ_W-1:0]     frequency_o,
  output logic                            decreased_o,
  output logic                            increased_o,
  output logic [aimd_pkg::FACTOR_W-1:0]   peak_factor_o
);
  import aimd_pkg::*;

  cfg_t cfg_q;
  logic alg_clr;
  reg_e cfg_idx;

  assign cfg_idx = reg_e'(cfg_idx_i);
  assign alg_clr = cfg_we_i && (cfg_idx == REG_ALGORITHM);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.algorithm         <= ALG_AIMD;
      cfg_q.increase_step     <= 16'd410;
      cfg_q.decrease_mult     <= 16'd32768;
      cfg_q.min_factor        <= 16'd410;
      cfg_q.max_factor        <= 16'd8192;
      cfg_q.increase_interval <= 10'd10;
      cfg_q.base_freq         <= 15'd7680;
      cfg_q.burst_factor      <= 16'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        REG_ALGORITHM:  cfg_q.algorithm         <= alg_e'(cfg_data_i[1:0]);
        REG_INC_STEP:   cfg_q.increase_step     <= cfg_data_i;
        REG_DEC_MULT:   cfg_q.decrease_mult     <= cfg_data_i;
        REG_MIN_FACTOR: cfg_q.min_factor        <= cfg_data_i;
        REG_MAX_FACTOR: cfg_q.max_factor        <= cfg_data_i;
        REG_INC_INTVL:  cfg_q.increase_interval <= cfg_data_i[COUNT_W-1:0];
        REG_BASE_FREQ:  cfg_q.base_freq         <= cfg_data_i[BASE_W-1:0];
        REG_BURST:      cfg_q.burst_factor      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aimd_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .alg_clr_i         (alg_clr),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .op_i              (op_i),
    .congestion_mark_i (congestion_mark_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .rate_factor_o     (rate_factor_o),
    .frequency_o       (frequency_o),
    .decreased_o       (decreased_o),
    .increased_o       (increased_o),
    .peak_factor_o     (peak_factor_o)
  );

endmodule

FILE: dv/aimd_rate_factor_controller_core_tb.sv
// Self-checking testbench for aimd_rate_factor_controller_core: a cycle-free rate-factor
// predictor, random handshake idling on both channels and per-field result checks.
// Depends on aimd_pkg and the core RTL only.
`timescale 1ns / 1ps

module aimd_rate_factor_controller_core_tb;
  import aimd_pkg::*;

  // One result beat as the block should present it
  typedef struct packed {
    logic [FACTOR_W-1:0] rate_factor;
    logic [FREQ_W-1:0]   frequency;
    logic                decreased;
    logic                increased;
    logic [FACTOR_W-1:0] peak_factor;
  } rate_beat_t;

  localparam int unsigned RAND_PHASES     = 8;
  localparam int unsigned EVENTS_PER_PHASE = 240;
  localparam int unsigned SETTLE_CYCLES   = 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  op = 1'b0;
  logic                  mark = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FACTOR_W-1:0]   rate_factor;
  logic [FREQ_W-1:0]     frequency;
  logic                  decreased;
  logic                  increased;
  logic [FACTOR_W-1:0]   peak_factor;

  // Predictor state and settings
  cfg_t                settings;
  logic [FACTOR_W-1:0] factor_q;
  logic [COUNT_W-1:0]  success_q;
  logic [FACTOR_W-1:0] peak_q;

  rate_beat_t  pending_rates[$];
  int unsigned mismatch_cnt = 0;

  // Idling controls shared by the sender, the receiver and the tests
  bit          quiet = 1'b0;
  bit          tx_idle_on = 1'b1;
  int unsigned hold_req = 0;

  always #5 clk = ~clk;

  aimd_rate_factor_controller_core dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .op_i              (op),
    .congestion_mark_i (mark),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .rate_factor_o     (rate_factor),
    .frequency_o       (frequency),
    .decreased_o       (decreased),
    .increased_o       (increased),
    .peak_factor_o     (peak_factor)
  );

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic reset_prediction();
    settings.algorithm         = ALG_AIMD;
    settings.increase_step     = 16'd410;
    settings.decrease_mult     = 16'd32768;
    settings.min_factor        = 16'd410;
    settings.max_factor        = 16'd8192;
    settings.increase_interval = 10'd10;
    settings.base_freq         = 15'd7680;
    settings.burst_factor      = 16'd4096;
    factor_q  = FACTOR_ONE;
    success_q = '0;
    peak_q    = '0;
  endtask

  // base * factor * burst in Q8.8 Hz, clamped to 0.1..200 Hz
  function automatic logic [FREQ_W-1:0] request_frequency();
    logic [63:0] prod;
    prod = 64'(settings.base_freq) * 64'(factor_q) * 64'(settings.burst_factor);
    prod = prod >> FREQ_SHIFT;
    if (prod < 64'(FREQ_MIN)) prod = 64'(FREQ_MIN);
    if (prod > 64'(FREQ_MAX)) prod = 64'(FREQ_MAX);
    return prod[FREQ_W-1:0];
  endfunction

  function automatic void cut_rate();
    logic [31:0] prod;
    prod = (32'(factor_q) * 32'(settings.decrease_mult)) >> 16;
    if (prod < 32'(settings.min_factor)) prod = 32'(settings.min_factor);
    factor_q  = prod[FACTOR_W-1:0];
    success_q = '0;
  endfunction

  // Advance the rate state by one event and return the beat it produces
  function automatic rate_beat_t predict_rate_update(logic ev_op, logic ev_mark);
    rate_beat_t beat;
    logic [16:0] sum;
    beat.decreased = 1'b0;
    beat.increased = 1'b0;
    if (settings.algorithm != ALG_NONE) begin
      if (ev_op) begin
        // timeout: mark ignored, peak untouched
        cut_rate();
        beat.decreased = 1'b1;
      end else if (ev_mark) begin
        cut_rate();
        beat.decreased = 1'b1;
        if (settings.algorithm == ALG_CUBIC) peak_q = factor_q;
      end else begin
        success_q = success_q + 1'b1;
        if (success_q >= settings.increase_interval) begin
          sum = 17'(factor_q) + 17'(settings.increase_step);
          if (sum > 17'(settings.max_factor)) sum = 17'(settings.max_factor);
          factor_q  = sum[FACTOR_W-1:0];
          success_q = '0;
          beat.increased = 1'b1;
        end
      end
    end
    beat.rate_factor = factor_q;
    beat.frequency   = request_frequency();
    beat.peak_factor = peak_q;
    return beat;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one event beat; returns once the block has taken it
  task automatic offer_event(input logic ev_op, input logic ev_mark);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 31) == 0) tx_idle_on = !tx_idle_on;
    if (tx_idle_on && !quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= ev_op;
    mark     <= ev_mark;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_rates.push_back(predict_rate_update(ev_op, ev_mark));
  endtask

  // Mostly unmarked arrivals so the increase path gets exercised
  task automatic offer_random_event();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8)       offer_event(1'b1, 1'($urandom_range(0, 1)));
    else if (pick < 22) offer_event(1'b0, 1'b1);
    else                offer_event(1'b0, 1'b0);
  endtask

  // Drop valid and let every outstanding beat come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; caller makes sure the block is idle
  task automatic write_reg(input reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_ALGORITHM: begin
        settings.algorithm = alg_e'(data[1:0]);
        factor_q  = FACTOR_ONE;
        success_q = '0;
        peak_q    = '0;
      end
      REG_INC_STEP:   settings.increase_step     = data;
      REG_DEC_MULT:   settings.decrease_mult     = data;
      REG_MIN_FACTOR: settings.min_factor        = data;
      REG_MAX_FACTOR: settings.max_factor        = data;
      REG_INC_INTVL:  settings.increase_interval = data[COUNT_W-1:0];
      REG_BASE_FREQ:  settings.base_freq         = data[BASE_W-1:0];
      REG_BURST:      settings.burst_factor      = data;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Either end of the range or anything between
  function automatic logic [CFG_DATA_W-1:0] pick_value(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 7))
      0:       return CFG_DATA_W'(lo);
      1:       return CFG_DATA_W'(hi);
      default: return CFG_DATA_W'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic apply_random_settings();
    int unsigned alg_pick;
    alg_pick = $urandom_range(0, 7);
    if ($urandom_range(0, 1) == 1) begin
      if (alg_pick == 0) write_reg(REG_ALGORITHM, CFG_DATA_W'(ALG_NONE));
      else               write_reg(REG_ALGORITHM, CFG_DATA_W'(1 + alg_pick % 3));
    end
    write_reg(REG_INC_STEP, pick_value(0, 65535));
    write_reg(REG_DEC_MULT, pick_value(0, 65535));
    write_reg(REG_MIN_FACTOR, ($urandom_range(0, 1) == 1) ? pick_value(0, 65535)
                                                        : pick_value(0, 2048));
    write_reg(REG_MAX_FACTOR, pick_value(0, 65535));
    case ($urandom_range(0, 7))
      0:       write_reg(REG_INC_INTVL, CFG_DATA_W'(0));
      1:       write_reg(REG_INC_INTVL, CFG_DATA_W'(1023));
      default: write_reg(REG_INC_INTVL, CFG_DATA_W'($urandom_range(0, 24)));
    endcase
    write_reg(REG_BASE_FREQ, pick_value(26, 25600));
    write_reg(REG_BURST, pick_value(410, 40960));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stall: random bursts, idle-free stretches, and long hold-offs
  // ---------------------------------------------------------------------------
  initial begin : rx_stall_gen
    int unsigned hold_left;
    int unsigned burst_left;
    bit          rx_idle_on;
    hold_left  = 0;
    burst_left = 0;
    rx_idle_on = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if ($urandom_range(0, 63) == 0) rx_idle_on = !rx_idle_on;
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (burst_left != 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else if (!quiet && rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        burst_left = $urandom_range(1, 9) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rate_beat_t seen;
    rate_beat_t want;
    if (out_valid && !out_stall) begin
      seen = '{rate_factor, frequency, decreased, increased, peak_factor};
      if (pending_rates.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("%0t: unexpected beat factor=%0d freq=%0d dec=%0b inc=%0b peak=%0d",
                   $realtime, seen.rate_factor, seen.frequency, seen.decreased,
                   seen.increased, seen.peak_factor);
        mismatch_cnt++;
      end else begin
        want = pending_rates.pop_front();
        if (seen.rate_factor !== want.rate_factor || seen.frequency !== want.frequency ||
            seen.decreased !== want.decreased || seen.increased !== want.increased ||
            seen.peak_factor !== want.peak_factor) begin
          if (mismatch_cnt < 10) begin
            $display("%0t: mismatch exp factor=%0d freq=%0d dec=%0b inc=%0b peak=%0d",
                     $realtime, want.rate_factor, want.frequency, want.decreased,
                     want.increased, want.peak_factor);
            $display("%0t:          got factor=%0d freq=%0d dec=%0b inc=%0b peak=%0d",
                     $realtime, seen.rate_factor, seen.frequency, seen.decreased,
                     seen.increased, seen.peak_factor);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: plain arrivals, timeout with mark set, marked arrival, plain timeout
  task automatic test_reset_defaults();
    repeat (3) offer_event(1'b0, 1'b0);
    offer_event(1'b1, 1'b1);
    offer_event(1'b0, 1'b1);
    offer_event(1'b1, 1'b0);
    wait_idle();
  endtask

  task automatic test_special_cases();
    // algorithm none holds everything
    write_reg(REG_ALGORITHM, CFG_DATA_W'(ALG_NONE));
    offer_event(1'b1, 1'b0);
    offer_event(1'b0, 1'b1);
    offer_event(1'b0, 1'b0);
    wait_idle();
    // cubic: marked arrival records peak, timeout leaves it
    write_reg(REG_ALGORITHM, CFG_DATA_W'(ALG_CUBIC));
    offer_event(1'b0, 1'b1);
    offer_event(1'b1, 1'b1);
    wait_idle();
    // zero interval: each unmarked arrival steps up
    write_reg(REG_INC_INTVL, CFG_DATA_W'(0));
    offer_event(1'b0, 1'b0);
    offer_event(1'b0, 1'b0);
    wait_idle();
    // ceiling dropped below the current factor pulls it down on the next step
    write_reg(REG_MAX_FACTOR, CFG_DATA_W'(1000));
    offer_event(1'b0, 1'b0);
    wait_idle();
    // rewriting the same algorithm restarts factor, count and peak
    write_reg(REG_ALGORITHM, CFG_DATA_W'(ALG_CUBIC));
    offer_event(1'b0, 1'b0);
    wait_idle();
    // zero multiplier and floor: factor hits zero, frequency clamps low
    write_reg(REG_DEC_MULT, CFG_DATA_W'(0));
    write_reg(REG_MIN_FACTOR, CFG_DATA_W'(0));
    offer_event(1'b1, 1'b0);
    wait_idle();
    // full step and ceiling, largest base and burst: frequency clamps high
    write_reg(REG_MAX_FACTOR, CFG_DATA_W'(65535));
    write_reg(REG_INC_STEP, CFG_DATA_W'(65535));
    write_reg(REG_BASE_FREQ, CFG_DATA_W'(25600));
    write_reg(REG_BURST, CFG_DATA_W'(40960));
    offer_event(1'b0, 1'b0);
    offer_event(1'b0, 1'b0);
    wait_idle();
  endtask

  // All registers at their lowest, then at their highest
  task automatic test_config_extremes();
    write_reg(REG_ALGORITHM, CFG_DATA_W'(ALG_AIMD));
    write_reg(REG_INC_STEP, CFG_DATA_W'(0));
    write_reg(REG_DEC_MULT, CFG_DATA_W'(0));
    write_reg(REG_MIN_FACTOR, CFG_DATA_W'(0));
    write_reg(REG_MAX_FACTOR, CFG_DATA_W'(0));
    write_reg(REG_INC_INTVL, CFG_DATA_W'(0));
    write_reg(REG_BASE_FREQ, CFG_DATA_W'(26));
    write_reg(REG_BURST, CFG_DATA_W'(410));
    repeat (40) offer_random_event();
    wait_idle();
    write_reg(REG_ALGORITHM, CFG_DATA_W'(ALG_CUBIC));
    write_reg(REG_INC_STEP, CFG_DATA_W'(65535));
    write_reg(REG_DEC_MULT, CFG_DATA_W'(65535));
    write_reg(REG_MIN_FACTOR, CFG_DATA_W'(65535));
    write_reg(REG_MAX_FACTOR, CFG_DATA_W'(65535));
    write_reg(REG_INC_INTVL, CFG_DATA_W'(1023));
    write_reg(REG_BASE_FREQ, CFG_DATA_W'(25600));
    write_reg(REG_BURST, CFG_DATA_W'(40960));
    repeat (40) offer_random_event();
    wait_idle();
  endtask

  // Receiver holds off long enough for the block to back up into its input
  task automatic test_backpressure();
    write_reg(REG_ALGORITHM, CFG_DATA_W'(ALG_BIC));
    write_reg(REG_INC_INTVL, CFG_DATA_W'(3));
    write_reg(REG_MIN_FACTOR, CFG_DATA_W'(410));
    write_reg(REG_MAX_FACTOR, CFG_DATA_W'(8192));
    write_reg(REG_DEC_MULT, CFG_DATA_W'(32768));
    write_reg(REG_INC_STEP, CFG_DATA_W'(410));
    hold_req = 300;
    repeat (24) offer_random_event();
    wait_idle();
  endtask

  // Random settings per phase; the last phase runs without idling
  task automatic test_random_phases();
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      apply_random_settings();
      if (ph == RAND_PHASES - 1) quiet = 1'b1;
      repeat (EVENTS_PER_PHASE) offer_random_event();
      wait_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned waited;
    reset_prediction();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_defaults();
    test_special_cases();
    test_config_extremes();
    test_backpressure();
    test_random_phases();

    // anything still owed counts as a failure
    waited = 0;
    while (pending_rates.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_rates.size() != 0) begin
      $display("%0d expected beats never arrived", pending_rates.size());
      mismatch_cnt += pending_rates.size();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
